// ----- sv/uds_diagnostic_responder_defines.svh -----
// assertion macros shared by the responder modules
`ifndef UDS_DIAGNOSTIC_RESPONDER_DEFINES_SVH
`define UDS_DIAGNOSTIC_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uds assertion failed");

// next-cycle implication
`define UDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uds assertion failed");

`else

`define UDS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UDS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/uds_pkg.sv -----
// types and constants of the diagnostic responder
package uds_pkg;

   // service identifiers
   localparam logic [7:0] SidSession  = 8'h10;
   localparam logic [7:0] SidEcuReset = 8'h11;
   localparam logic [7:0] SidReadDid  = 8'h22;
   localparam logic [7:0] SidSecurity = 8'h27;
   localparam logic [7:0] SidTester   = 8'h3E;

   // positive response identifiers
   localparam logic [7:0] RspSession  = 8'h50;
   localparam logic [7:0] RspEcuReset = 8'h51;
   localparam logic [7:0] RspReadDid  = 8'h62;
   localparam logic [7:0] RspSecurity = 8'h67;
   localparam logic [7:0] RspTester   = 8'h7E;
   localparam logic [7:0] RspNegative = 8'h7F;

   // negative response codes
   localparam logic [7:0] NrcNotSupported = 8'h11;
   localparam logic [7:0] NrcSubFunction  = 8'h12;
   localparam logic [7:0] NrcLength       = 8'h13;
   localparam logic [7:0] NrcConditions   = 8'h22;
   localparam logic [7:0] NrcRange        = 8'h31;
   localparam logic [7:0] NrcInvalidKey   = 8'h35;

   // subfunctions
   localparam logic [7:0] SubDefaultSession  = 8'h01;
   localparam logic [7:0] SubExtendedSession = 8'h03;
   localparam logic [7:0] SubHardReset       = 8'h01;
   localparam logic [7:0] SubRequestSeed     = 8'h01;
   localparam logic [7:0] SubSendKey         = 8'h02;
   localparam logic [7:0] SubTesterZero      = 8'h00;

   // data identifiers
   localparam logic [15:0] DidVin  = 16'hF190;
   localparam logic [15:0] DidRpm  = 16'h0202;
   localparam logic [15:0] DidRoad = 16'h0203;

   // session timing bytes (p2 and p2 star)
   localparam logic [7:0] P2High     = 8'h00;
   localparam logic [7:0] P2Low      = 8'h32;
   localparam logic [7:0] P2StarHigh = 8'h01;
   localparam logic [7:0] P2StarLow  = 8'hF4;

   localparam logic [31:0] KeyMask  = 32'hDEADBEEF;
   localparam logic [28:0] StdIdMax = 29'h7FF;

   // configuration register indexes
   localparam int CsrIndexW = 3;
   localparam logic [CsrIndexW-1:0] CsrVinFirst  = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrVinMiddle = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrVinFinal  = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrIdStd     = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrIdExt     = 3'd4;

   // reply geometry
   localparam int ShortBytes  = 6;
   localparam int VinChars    = 17;
   localparam int VinHeader   = 3;
   localparam int CountW      = 5;
   localparam int ByteSelW    = $clog2(ShortBytes);
   localparam int VinSelW     = $clog2(VinChars);

   // job queue
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // one reply to produce
   typedef struct packed {
      logic [CountW-1:0]              count;
      logic [0:ShortBytes-1][7:0]     bytes;
      logic                           is_vin;
      logic                           is_ext;
   } job_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [63:0] vin_bytes_first;
      logic [63:0] vin_bytes_middle;
      logic [7:0]  vin_byte_final;
      logic [10:0] reply_id_standard;
      logic [28:0] reply_id_extended;
   } cfg_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- sv/uds_if.sv -----
// request and response channel interfaces
interface uds_req_if;
   logic        valid;
   logic        ready;
   logic [28:0] request_can_id;
   logic [11:0] request_length;
   logic [7:0]  request_byte_0;
   logic [7:0]  request_byte_1;
   logic [7:0]  request_byte_2;
   logic [7:0]  request_byte_3;
   logic [7:0]  request_byte_4;
   logic [7:0]  request_byte_5;
   logic [31:0] random_seed;
   logic [13:0] engine_speed;
   logic [7:0]  road_speed;

   modport source (
      output valid, request_can_id, request_length, request_byte_0, request_byte_1,
         request_byte_2, request_byte_3, request_byte_4, request_byte_5, random_seed,
         engine_speed, road_speed,
      input  ready
   );
   modport sink (
      input  valid, request_can_id, request_length, request_byte_0, request_byte_1,
         request_byte_2, request_byte_3, request_byte_4, request_byte_5, random_seed,
         engine_speed, road_speed,
      output ready
   );
endinterface

interface uds_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  response_byte;
   logic        response_last;
   logic [28:0] reply_id;
   logic        reply_is_extended;

   modport source (
      output valid, response_byte, response_last, reply_id, reply_is_extended,
      input  ready
   );
   modport sink (
      input  valid, response_byte, response_last, reply_id, reply_is_extended,
      output ready
   );
endinterface

// ----- sv/uds_front.sv -----
// front end: accepts requests, updates session and security state, queues replies
module uds_front import uds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   uds_req_if.sink          req_chan,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          job
);

   logic        session_ff, session_in;
   logic        unlocked_ff, unlocked_in;
   logic [31:0] seed_ff, seed_in;
   logic        accept;
   logic [11:0] len;
   logic [7:0]  b0, b1, b2;
   logic [15:0] did;
   logic [31:0] key;
   logic [15:0] rpm_x4;

   function automatic job_type neg_job(input logic [7:0] svc, input logic [7:0] code);
      job_type j;
      j        = '0;
      j.count  = CountW'(3);
      j.bytes  = {RspNegative, svc, code, 8'h00, 8'h00, 8'h00};
      return j;
   endfunction

   assign req_chan.ready = !q_status.full;
   assign accept = req_chan.valid && req_chan.ready;
   assign len    = req_chan.request_length;
   assign b0     = req_chan.request_byte_0;
   assign b1     = req_chan.request_byte_1;
   assign b2     = req_chan.request_byte_2;
   assign did    = {b1, b2};
   assign key    = {req_chan.request_byte_2, req_chan.request_byte_3,
                    req_chan.request_byte_4, req_chan.request_byte_5};
   assign rpm_x4 = {req_chan.engine_speed, 2'b00};
   assign push   = accept && (len != 12'd0);

   always_comb begin
      job         = '0;
      session_in  = session_ff;
      unlocked_in = unlocked_ff;
      seed_in     = seed_ff;
      unique case (b0)
         SidSession: begin
            if (len != 12'd2) begin
               job = neg_job(SidSession, NrcLength);
            end else if (b1 == SubDefaultSession || b1 == SubExtendedSession) begin
               session_in  = (b1 == SubExtendedSession);
               unlocked_in = 1'b0;
               job.count   = CountW'(6);
               job.bytes   = {RspSession, b1, P2High, P2Low, P2StarHigh, P2StarLow};
            end else begin
               job = neg_job(SidSession, NrcSubFunction);
            end
         end
         SidEcuReset: begin
            if (len != 12'd2) begin
               job = neg_job(SidEcuReset, NrcLength);
            end else if (b1 == SubHardReset) begin
               session_in  = 1'b0;
               unlocked_in = 1'b0;
               job.count   = CountW'(2);
               job.bytes   = {RspEcuReset, SubHardReset, 8'h00, 8'h00, 8'h00, 8'h00};
            end else begin
               job = neg_job(SidEcuReset, NrcSubFunction);
            end
         end
         SidReadDid: begin
            if (len != 12'd3) begin
               job = neg_job(SidReadDid, NrcLength);
            end else if (did == DidVin) begin
               job.count  = CountW'(VinHeader + VinChars);
               job.bytes  = {RspReadDid, b1, b2, 8'h00, 8'h00, 8'h00};
               job.is_vin = 1'b1;
            end else if (did == DidRpm) begin
               if (!session_ff) begin
                  job = neg_job(SidReadDid, NrcConditions);
               end else begin
                  job.count = CountW'(5);
                  job.bytes = {RspReadDid, b1, b2, rpm_x4[15:8], rpm_x4[7:0], 8'h00};
               end
            end else if (did == DidRoad) begin
               job.count = CountW'(4);
               job.bytes = {RspReadDid, b1, b2, req_chan.road_speed, 8'h00, 8'h00};
            end else begin
               job = neg_job(SidReadDid, NrcRange);
            end
         end
         SidSecurity: begin
            if (len != 12'd2 && len != 12'd6) begin
               job = neg_job(SidSecurity, NrcLength);
            end else if (b1 == SubRequestSeed) begin
               if (len != 12'd2) begin
                  job = neg_job(SidSecurity, NrcLength);
               end else if (!session_ff) begin
                  job = neg_job(SidSecurity, NrcConditions);
               end else begin
                  seed_in   = req_chan.random_seed;
                  job.count = CountW'(6);
                  job.bytes = {RspSecurity, SubRequestSeed, req_chan.random_seed};
               end
            end else if (b1 == SubSendKey) begin
               if (len != 12'd6) begin
                  job = neg_job(SidSecurity, NrcLength);
               end else if (seed_ff == 32'd0) begin
                  job = neg_job(SidSecurity, NrcRange);
               end else if (key == (seed_ff ^ KeyMask)) begin
                  unlocked_in = 1'b1;
                  seed_in     = 32'd0;
                  job.count   = CountW'(2);
                  job.bytes   = {RspSecurity, SubSendKey, 8'h00, 8'h00, 8'h00, 8'h00};
               end else begin
                  unlocked_in = 1'b0;
                  job = neg_job(SidSecurity, NrcInvalidKey);
               end
            end else begin
               job = neg_job(SidSecurity, NrcSubFunction);
            end
         end
         SidTester: begin
            if (len != 12'd2) begin
               job = neg_job(SidTester, NrcLength);
            end else if (b1 == SubTesterZero) begin
               job.count = CountW'(2);
               job.bytes = {RspTester, SubTesterZero, 8'h00, 8'h00, 8'h00, 8'h00};
            end else begin
               job = neg_job(SidTester, NrcSubFunction);
            end
         end
         default: begin
            job = neg_job(b0, NrcNotSupported);
         end
      endcase
      job.is_ext = (req_chan.request_can_id > StdIdMax);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff  <= 1'b0;
         unlocked_ff <= 1'b0;
         seed_ff     <= 32'd0;
      end else if (push) begin
         session_ff  <= session_in;
         unlocked_ff <= unlocked_in;
         seed_ff     <= seed_in;
      end
   end

endmodule

// ----- sv/uds_job_queue.sv -----
// short queue of reply jobs between front and back end
`include "uds_diagnostic_responder_defines.svh"
module uds_job_queue import uds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `UDS_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !status.full)
   `UDS_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !status.empty)

endmodule

// ----- sv/uds_back.sv -----
// back end: streams each queued reply out one byte per cycle while the sink holds ready high
`include "uds_diagnostic_responder_defines.svh"
module uds_back import uds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   uds_rsp_if.source        rsp_chan
);

   logic [CountW-1:0]            idx_ff, idx_in;
   logic                         valid_ff, valid_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         last_ff, last_in;
   logic [28:0]                  id_ff, id_in;
   logic                         ext_ff, ext_in;
   logic                         load;
   logic                         head_valid;
   logic                         is_last;
   logic [VinChars-1:0][7:0]     vin_chars;
   logic [CountW-1:0]            vin_off;
   logic [VinSelW-1:0]           vin_sel;
   logic [ByteSelW-1:0]          byte_sel;

   // vin characters, first character at index zero
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         vin_chars[i]     = cfg.vin_bytes_first[63 - 8 * i -: 8];
         vin_chars[i + 8] = cfg.vin_bytes_middle[63 - 8 * i -: 8];
      end
      vin_chars[VinChars - 1] = cfg.vin_byte_final;
   end

   assign head_valid = !q_status.empty;
   assign load       = !valid_ff || rsp_chan.ready;
   assign is_last    = (idx_ff == head.count - 1'b1);
   assign pop        = load && head_valid && is_last;
   assign vin_off    = idx_ff - CountW'(VinHeader);
   assign vin_sel    = vin_off[VinSelW-1:0];
   assign byte_sel   = idx_ff[ByteSelW-1:0];

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      id_in    = id_ff;
      ext_in   = ext_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            idx_in  = is_last ? '0 : idx_ff + 1'b1;
            last_in = is_last;
            ext_in  = head.is_ext;
            id_in   = head.is_ext ? cfg.reply_id_extended : 29'(cfg.reply_id_standard);
            if (head.is_vin && idx_ff >= CountW'(VinHeader)) begin
               byte_in = vin_chars[vin_sel];
            end else begin
               byte_in = head.bytes[byte_sel];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      id_ff   <= id_in;
      ext_ff  <= ext_in;
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.response_byte     = byte_ff;
   assign rsp_chan.response_last     = last_ff;
   assign rsp_chan.reply_id          = id_ff;
   assign rsp_chan.reply_is_extended = ext_ff;

   `UDS_ASSERT_IMPLY(a_idx_in_range, clock, reset, head_valid, idx_ff < head.count)
   `UDS_ASSERT_NEXT(a_idx_restart, clock, reset, pop, idx_ff == '0)
   `UDS_ASSERT_NEXT(a_last_on_pop, clock, reset, pop, valid_ff && last_ff)

endmodule

// ----- sv/uds_diagnostic_responder.sv -----
// top level of the diagnostic responder: config registers, front end, queue, back end
//
//   channel   direction  handshake            payload
//   req_chan  in         valid / ready        request id, length, bytes 0..5, seed, speeds
//   rsp_chan  out        valid / ready        reply byte, last flag, reply id, extended flag
//   csr_*     in         write enable only    3-bit index, 64-bit write data
//
// a request is classified and its state effects applied in the cycle it is accepted
// a reply of n bytes (2 to 20) leaves the back end one byte per cycle while the sink holds ready high
// the two-entry job queue lets the front take a new request every cycle while it has room
// the output register keeps streaming while the sink holds ready high; a stall only
// fills the queue and then drops req ready
// synchronous reset clears session, security, seed, queue and config registers
module uds_diagnostic_responder import uds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   uds_req_if.sink              req_chan,
   uds_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [63:0]          csr_write_data
);

   // configuration registers
   cfg_type          cfg_ff;
   cfg_type          cfg_in;

   // front to queue
   logic             push;
   job_type          push_job;

   // queue to back
   logic             pop;
   job_type          head;
   queue_status_type q_status;

   // csr write decode, indexes beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrVinFirst:  cfg_in.vin_bytes_first   = csr_write_data;
            CsrVinMiddle: cfg_in.vin_bytes_middle  = csr_write_data;
            CsrVinFinal:  cfg_in.vin_byte_final    = csr_write_data[7:0];
            CsrIdStd:     cfg_in.reply_id_standard = csr_write_data[10:0];
            CsrIdExt:     cfg_in.reply_id_extended = csr_write_data[28:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify the request and apply its state effects
   uds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   // decouples acceptance from byte streaming
   uds_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // serialize the reply bytes
   uds_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
